// File: sv/pdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types, fixed-point constants and helper functions of the dq0 unit.
// ----------------------------------------------------------------------------
package pdq_pkg;

  typedef enum logic {
    OpFwd = 1'b0,
    OpInv = 1'b1
  } pdq_op_e;

  typedef struct packed {
    logic    vld;
    pdq_op_e op;
  } pdq_ctl_t;

  localparam int CoefW       = 32;
  localparam int SinW        = 31;
  localparam int ProdW       = 63;
  localparam int TaylorTerms = 12;

  localparam logic [SinW-1:0]         SinOne       = 31'h4000_0000;
  localparam logic [63:0]             PihQ30       = 64'd1686629713;
  localparam logic signed [CoefW-1:0] HalfSqrt3Q30 = 32'sd929887697;

  function automatic logic [SinW-1:0] sin_entry(input int unsigned idx,
                                                input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (PihQ30 * 64'(idx) + ((64'd1 << bits) >> 1)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= TaylorTerms; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    return sum[SinW-1:0];
  endfunction

  function automatic logic signed [CoefW-1:0] rnd_q30(input logic signed [ProdW-1:0] p);
    logic [ProdW-1:0]        mag;
    logic [ProdW-1:0]        r;
    logic signed [CoefW-1:0] rv;
    mag = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    r   = (mag + (ProdW'(1) << 29)) >> 30;
    rv  = r[CoefW-1:0];
    return p[ProdW-1] ? -rv : rv;
  endfunction

  function automatic logic signed [CoefW-1:0] rnd_half(input logic signed [CoefW-1:0] v);
    logic [CoefW-1:0]        mag;
    logic [CoefW-1:0]        r;
    logic signed [CoefW-1:0] rv;
    mag = v[CoefW-1] ? CoefW'(-v) : CoefW'(v);
    r   = (mag + CoefW'(1)) >> 1;
    rv  = r;
    return v[CoefW-1] ? -rv : rv;
  endfunction

endpackage

// File: sv/pdq_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_angle
// Angle quantization, quadrant folding and quarter-wave sine/cosine lookup.
// ----------------------------------------------------------------------------
module pdq_angle #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int ANGLE_WIDTH     = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  pdq_pkg::pdq_ctl_t                      ctl_i,
  input  logic [ANGLE_WIDTH-1:0]                 angle_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         x_i [3],
  output pdq_pkg::pdq_ctl_t                      ctl_o,
  output logic signed [pdq_pkg::CoefW-1:0]       sin_o,
  output logic signed [pdq_pkg::CoefW-1:0]       cos_o,
  output logic signed [SAMPLE_WIDTH-1:0]         x_o [3]
);
  import pdq_pkg::*;

  localparam int TB    = SINE_TABLE_BITS + 2;
  localparam int TabN  = 1 << SINE_TABLE_BITS;
  localparam int AddrW = SINE_TABLE_BITS + 1;

  logic [SinW-1:0] sin_rom [TabN+1];

  for (genvar gi = 0; gi <= TabN; gi++) begin : g_rom
    localparam logic [SinW-1:0] Entry = (gi == TabN) ? SinOne : sin_entry(gi, SINE_TABLE_BITS);
    assign sin_rom[gi] = Entry;
  end

  function automatic logic [AddrW:0] fold(input logic [TB-1:0] i);
    logic [1:0]       quad;
    logic [AddrW-1:0] r;
    quad = i[TB-1 -: 2];
    r    = AddrW'(i[SINE_TABLE_BITS-1:0]);
    return {quad[1], quad[0] ? (AddrW'(TabN) - r) : r};
  endfunction

  logic [TB-1:0] idx;
  logic [TB-1:0] idx_c;

  if (ANGLE_WIDTH > TB) begin : g_round
    localparam int Sh = ANGLE_WIDTH - TB;
    logic [ANGLE_WIDTH-1:0] sum;
    assign sum = angle_i + (ANGLE_WIDTH'(1) << (Sh - 1));
    assign idx = sum[ANGLE_WIDTH-1 -: TB];
  end else begin : g_shift
    assign idx = TB'(angle_i) << (TB - ANGLE_WIDTH);
  end

  assign idx_c = idx + TB'(TabN);

  pdq_ctl_t                     ctl1_q;
  logic [AddrW:0]               fs_d, fs_q;
  logic [AddrW:0]               fc_d, fc_q;
  logic signed [SAMPLE_WIDTH-1:0] x1_q [3];
  logic [SinW-1:0]              mag_s;
  logic [SinW-1:0]              mag_c;
  logic signed [CoefW-1:0]      sin_d, sin_q;
  logic signed [CoefW-1:0]      cos_d, cos_q;
  pdq_ctl_t                     ctl2_q;
  logic signed [SAMPLE_WIDTH-1:0] x2_q [3];

  assign fs_d = fold(idx);
  assign fc_d = fold(idx_c);

  assign mag_s = sin_rom[fs_q[AddrW-1:0]];
  assign mag_c = sin_rom[fc_q[AddrW-1:0]];
  assign sin_d = fs_q[AddrW] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  assign cos_d = fc_q[AddrW] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fs_q  <= fs_d;
      fc_q  <= fc_d;
      x1_q  <= x_i;
      sin_q <= sin_d;
      cos_q <= cos_d;
      x2_q  <= x1_q;
    end
  end

  assign ctl_o = ctl2_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;
  assign x_o   = x2_q;

endmodule

// File: sv/pdq_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_coef
// Builds the six rotation coefficients for the three phase angles.
// ----------------------------------------------------------------------------
module pdq_coef #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  pdq_pkg::pdq_ctl_t                      ctl_i,
  input  logic signed [pdq_pkg::CoefW-1:0]       sin_i,
  input  logic signed [pdq_pkg::CoefW-1:0]       cos_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         x_i [3],
  output pdq_pkg::pdq_ctl_t                      ctl_o,
  output logic signed [pdq_pkg::CoefW-1:0]       cf_o [3],
  output logic signed [pdq_pkg::CoefW-1:0]       sn_o [3],
  output logic signed [SAMPLE_WIDTH-1:0]         x_o [3]
);
  import pdq_pkg::*;

  pdq_ctl_t                       ctl3_q, ctl4_q, ctl5_q;
  logic signed [ProdW-1:0]        phs_d, phs_q;
  logic signed [ProdW-1:0]        phc_d, phc_q;
  logic signed [CoefW-1:0]        s3_q, c3_q;
  logic signed [SAMPLE_WIDTH-1:0] x3_q [3];
  logic signed [CoefW-1:0]        hs_q, hc_q, sh_q, ch_q;
  logic signed [CoefW-1:0]        s4_q, c4_q;
  logic signed [SAMPLE_WIDTH-1:0] x4_q [3];
  logic signed [CoefW-1:0]        cf_d [3];
  logic signed [CoefW-1:0]        sn_d [3];
  logic signed [CoefW-1:0]        cf_q [3];
  logic signed [CoefW-1:0]        sn_q [3];
  logic signed [SAMPLE_WIDTH-1:0] x5_q [3];

  assign phs_d = ProdW'(sin_i) * ProdW'(HalfSqrt3Q30);
  assign phc_d = ProdW'(cos_i) * ProdW'(HalfSqrt3Q30);

  assign cf_d[0] = c4_q;
  assign cf_d[1] = hs_q - ch_q;
  assign cf_d[2] = -ch_q - hs_q;
  assign sn_d[0] = s4_q;
  assign sn_d[1] = -sh_q - hc_q;
  assign sn_d[2] = hc_q - sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl3_q <= ctl_i;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phs_q <= phs_d;
      phc_q <= phc_d;
      s3_q  <= sin_i;
      c3_q  <= cos_i;
      x3_q  <= x_i;
      hs_q  <= rnd_q30(phs_q);
      hc_q  <= rnd_q30(phc_q);
      sh_q  <= rnd_half(s3_q);
      ch_q  <= rnd_half(c3_q);
      s4_q  <= s3_q;
      c4_q  <= c3_q;
      x4_q  <= x3_q;
      cf_q  <= cf_d;
      sn_q  <= sn_d;
      x5_q  <= x4_q;
    end
  end

  assign ctl_o = ctl5_q;
  assign cf_o  = cf_q;
  assign sn_o  = sn_q;
  assign x_o   = x5_q;

endmodule

// File: sv/pdq_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_mac
// Coefficient-by-sample products and the three weighted sums.
// ----------------------------------------------------------------------------
module pdq_mac #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  pdq_pkg::pdq_ctl_t                             ctl_i,
  input  logic signed [pdq_pkg::CoefW-1:0]              cf_i [3],
  input  logic signed [pdq_pkg::CoefW-1:0]              sn_i [3],
  input  logic signed [SAMPLE_WIDTH-1:0]                x_i [3],
  output pdq_pkg::pdq_ctl_t                             ctl_o,
  output logic signed [SAMPLE_WIDTH+pdq_pkg::CoefW+1:0] num_o [3]
);
  import pdq_pkg::*;

  localparam int MW = SAMPLE_WIDTH + CoefW;
  localparam int NW = MW + 2;

  pdq_ctl_t                       ctl6_q, ctl7_q;
  logic signed [SAMPLE_WIDTH-1:0] xa [3];
  logic signed [SAMPLE_WIDTH-1:0] xb [3];
  logic signed [MW-1:0]           mc_d [3];
  logic signed [MW-1:0]           ms_d [3];
  logic signed [MW-1:0]           mc_q [3];
  logic signed [MW-1:0]           ms_q [3];
  logic signed [SAMPLE_WIDTH-1:0] x6_q [3];
  logic signed [NW-1:0]           zs;
  logic signed [NW-1:0]           num_d [3];
  logic signed [NW-1:0]           num_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign xa[k]   = (ctl_i.op == OpInv) ? x_i[0] : x_i[k];
    assign xb[k]   = (ctl_i.op == OpInv) ? x_i[1] : x_i[k];
    assign mc_d[k] = MW'(cf_i[k]) * MW'(xa[k]);
    assign ms_d[k] = MW'(sn_i[k]) * MW'(xb[k]);
  end

  assign zs = NW'(x6_q[2]) <<< 30;

  always_comb begin
    unique case (ctl6_q.op)
      OpFwd: begin
        num_d[0] = NW'(mc_q[0]) + NW'(mc_q[1]) + NW'(mc_q[2]);
        num_d[1] = -(NW'(ms_q[0]) + NW'(ms_q[1]) + NW'(ms_q[2]));
        num_d[2] = NW'(x6_q[0]) + NW'(x6_q[1]) + NW'(x6_q[2]);
      end
      OpInv: begin
        for (int k = 0; k < 3; k++) begin
          num_d[k] = NW'(mc_q[k]) - NW'(ms_q[k]) + zs;
        end
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          num_d[k] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl6_q <= '0;
      ctl7_q <= '0;
    end else if (en_i) begin
      ctl6_q <= ctl_i;
      ctl7_q <= ctl6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mc_q  <= mc_d;
      ms_q  <= ms_d;
      x6_q  <= x_i;
      num_q <= num_d;
    end
  end

  assign ctl_o = ctl7_q;
  assign num_o = num_q;

endmodule

// File: sv/pdq_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_round
// Rounds the sums half away from zero, divides by three in forward mode, saturates.
// ----------------------------------------------------------------------------
module pdq_round #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  pdq_pkg::pdq_ctl_t                             ctl_i,
  input  logic signed [SAMPLE_WIDTH+pdq_pkg::CoefW+1:0] num_i [3],
  output pdq_pkg::pdq_ctl_t                             ctl_o,
  output logic signed [SAMPLE_WIDTH-1:0]                out_o [3],
  output logic                                          sat_o
);
  import pdq_pkg::*;

  localparam int NW = SAMPLE_WIDTH + CoefW + 2;
  localparam int TW = SAMPLE_WIDTH + 1;
  localparam int QW = SAMPLE_WIDTH;

  localparam logic [NW:0]   RndF  = (NW + 1)'(3) << 28;
  localparam logic [NW:0]   RndI  = (NW + 1)'(1) << 29;
  localparam logic [NW:0]   TMaxF = ((NW + 1)'(3) << (SAMPLE_WIDTH - 1)) + (NW + 1)'(3);
  localparam logic [NW:0]   TMaxI = ((NW + 1)'(1) << (SAMPLE_WIDTH - 1)) + (NW + 1)'(1);
  localparam logic [TW-1:0] Recip = TW'(((64'd1 << (TW + 1)) + 64'd2) / 64'd3);

  pdq_ctl_t                       ctl8_q, ctl9_q, ctl10_q;
  logic [TW-1:0]                  tc_d [3];
  logic [TW-1:0]                  tc_q [3];
  logic                           neg_d [3];
  logic                           neg8_q [3];
  logic                           neg9_q [3];
  logic [QW-1:0]                  q_d [3];
  logic [QW-1:0]                  q_q [3];
  logic signed [SAMPLE_WIDTH-1:0] out_d [3];
  logic signed [SAMPLE_WIDTH-1:0] out_q [3];
  logic [2:0]                     clip;
  logic                           sat_d, sat_q;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [NW:0]     mag;
    logic [NW:0]     tf;
    logic [NW:0]     ti;
    logic [NW:0]     tz;
    logic [NW:0]     t;
    logic [NW:0]     lim;
    logic [2*TW-1:0] prod;
    logic            ovf_pos;
    logic            ovf_neg;

    assign neg_d[k] = num_i[k][NW-1];
    assign mag      = neg_d[k] ? (NW + 1)'(-num_i[k]) : (NW + 1)'(num_i[k]);
    assign tf       = (mag + RndF) >> 29;
    assign ti       = (mag + RndI) >> 30;
    assign tz       = mag + (NW + 1)'(1);

    always_comb begin
      unique case (ctl_i.op)
        OpFwd:   t = (k == 2) ? tz : tf;
        OpInv:   t = ti;
        default: t = '0;
      endcase
    end

    assign lim      = (ctl_i.op == OpInv) ? TMaxI : TMaxF;
    assign tc_d[k]  = (t > lim) ? lim[TW-1:0] : t[TW-1:0];

    assign prod     = (2 * TW)'(tc_q[k]) * (2 * TW)'(Recip);
    assign q_d[k]   = (ctl8_q.op == OpInv) ? tc_q[k][QW-1:0] : prod[2*TW-1 : TW+1];

    assign ovf_pos  = !neg9_q[k] && q_q[k][QW-1];
    assign ovf_neg  = neg9_q[k] && q_q[k][QW-1] && (|q_q[k][QW-2:0]);
    assign clip[k]  = ovf_pos || ovf_neg;

    always_comb begin
      priority if (ovf_pos) begin
        out_d[k] = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
      end else if (ovf_neg) begin
        out_d[k] = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
      end else if (neg9_q[k]) begin
        out_d[k] = -$signed(q_q[k]);
      end else begin
        out_d[k] = $signed(q_q[k]);
      end
    end
  end

  assign sat_d = |clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl8_q  <= '0;
      ctl9_q  <= '0;
      ctl10_q <= '0;
    end else if (en_i) begin
      ctl8_q  <= ctl_i;
      ctl9_q  <= ctl8_q;
      ctl10_q <= ctl9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tc_q   <= tc_d;
      neg8_q <= neg_d;
      q_q    <= q_d;
      neg9_q <= neg8_q;
      out_q  <= out_d;
      sat_q  <= sat_d;
    end
  end

  assign ctl_o = ctl10_q;
  assign out_o = out_q;
  assign sat_o = sat_q;

endmodule

// File: sv/park_dq0_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// park_dq0_transform_unit
// Amplitude-invariant Park transform, abc to dq0 and dq0 to abc.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser selects forward (0) or inverse (1); s_axis_tdata
// carries the rotor angle and three signed Q1.15 components. Output stream:
// m_axis_tdata carries three saturated Q1.15 results, m_axis_tuser flags a
// word in which any result was clipped.
// Every input word yields exactly one output word, in order.
// The pipeline from input handshake to m_axis_tvalid has two stages of
// angle folding and quarter-wave table read, three of coefficient build,
// two of multiply and sum, three of rounding, division by three and
// saturation. Throughput is one word per cycle unless the output stalls.
// Reset clears every stage's valid bit; the pipeline comes up empty.
// A stall on m_axis_tready while the output holds a word freezes all stages
// together and drops s_axis_tready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module park_dq0_transform_unit #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int ANGLE_WIDTH     = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               s_axis_tvalid,
  output logic                                               s_axis_tready,
  // angle, comp_first, comp_second, comp_third, zero fill
  input  logic [((ANGLE_WIDTH+3*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // opcode
  input  logic                                               s_axis_tuser,
  output logic                                               m_axis_tvalid,
  input  logic                                               m_axis_tready,
  // out_first, out_second, out_third, zero fill
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]                m_axis_tdata,
  // saturated
  output logic                                               m_axis_tuser
);
  import pdq_pkg::*;

  localparam int OutBW = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int NW    = SAMPLE_WIDTH + CoefW + 2;

  logic                           en;
  pdq_ctl_t                       ctl_in;
  logic signed [SAMPLE_WIDTH-1:0] x_in [3];
  pdq_ctl_t                       ctl_a, ctl_c, ctl_m, ctl_r;
  logic signed [CoefW-1:0]        sin_a, cos_a;
  logic signed [SAMPLE_WIDTH-1:0] x_a [3];
  logic signed [SAMPLE_WIDTH-1:0] x_c [3];
  logic signed [CoefW-1:0]        cf_c [3];
  logic signed [CoefW-1:0]        sn_c [3];
  logic signed [NW-1:0]           num_m [3];
  logic signed [SAMPLE_WIDTH-1:0] res [3];
  logic                           sat;

  assign en            = !ctl_r.vld || m_axis_tready;
  assign s_axis_tready = en;

  assign ctl_in.vld = s_axis_tvalid;
  assign ctl_in.op  = pdq_op_e'(s_axis_tuser);

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign x_in[k] = s_axis_tdata[ANGLE_WIDTH + k * SAMPLE_WIDTH +: SAMPLE_WIDTH];
  end

  pdq_angle #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .ANGLE_WIDTH    (ANGLE_WIDTH),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_in),
    .angle_i(s_axis_tdata[ANGLE_WIDTH-1:0]),
    .x_i    (x_in),
    .ctl_o  (ctl_a),
    .sin_o  (sin_a),
    .cos_o  (cos_a),
    .x_o    (x_a)
  );

  pdq_coef #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_coef (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctl_i (ctl_a),
    .sin_i (sin_a),
    .cos_i (cos_a),
    .x_i   (x_a),
    .ctl_o (ctl_c),
    .cf_o  (cf_c),
    .sn_o  (sn_c),
    .x_o   (x_c)
  );

  pdq_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctl_i (ctl_c),
    .cf_i  (cf_c),
    .sn_i  (sn_c),
    .x_i   (x_c),
    .ctl_o (ctl_m),
    .num_o (num_m)
  );

  pdq_round #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_round (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctl_i (ctl_m),
    .num_i (num_m),
    .ctl_o (ctl_r),
    .out_o (res),
    .sat_o (sat)
  );

  assign m_axis_tvalid = ctl_r.vld;
  assign m_axis_tdata  = OutBW'({res[2], res[1], res[0]});
  assign m_axis_tuser  = sat;

endmodule
